// ----- hw/rtl/q31nr_pkg.sv -----
// Package for the Q31 Newton-Raphson divider: constants, shared types and
// the saturating 64-bit add and subtract helpers.
// Depends on nothing; every other file of the divider but q31nr_if imports it.
`default_nettype none

package q31nr_pkg;

  // Default configuration handed down from the top level.
  localparam int NR_ITERATIONS_DEF = 3;
  localparam int FRAC_BITS_DEF     = 25;

  // Seed line of the reciprocal estimate: OFFSET - (SLOPE * d) >> FRAC_BITS.
  localparam logic [63:0]        SEED_OFFSET = 64'd94742680;
  localparam int                 SLOPE_W     = 27;
  localparam logic signed [26:0] SEED_SLOPE  = 27'sd63161788;

  // Q31 and 64-bit extremes.
  localparam logic [31:0] Q31_MIN = 32'h8000_0000;
  localparam logic [31:0] Q31_MAX = 32'h7FFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Register enables of the two stages of a pipelined 64-bit multiplier.
  typedef struct packed {
    logic pp;
    logic sum;
  } mul_en_t;

  // Signed 64-bit add that clamps on overflow.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) begin
      sat_add64 = a[63] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_add64 = r;
    end
  endfunction

  // Signed 64-bit subtract that clamps on overflow.
  function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) begin
      sat_sub64 = a[63] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_sub64 = r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/q31nr_if.sv -----
// Valid/ready channel interfaces of the Q31 divider: operand input and
// quotient output. No dependencies.
`default_nettype none

// Operand channel: one transaction carries a dividend and a divisor.
interface q31nr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] dividend;
  logic [31:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

// Result channel: one transaction carries a quotient.
interface q31nr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink (input valid, input quotient, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/q31nr_mul64.sv -----
// Two-stage multiplier that returns the low 64 bits of a 64 x 64 product.
// Depends on q31nr_pkg; the instantiating pipeline owns the valid bits.
`default_nettype none

module q31nr_mul64
  import q31nr_pkg::*;
(
  input  wire logic        clk,
  input  wire mul_en_t     en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);

  logic [63:0] pll_nxt, pll_r;
  logic [31:0] phl_nxt, phl_r;
  logic [31:0] plh_nxt, plh_r;
  logic [31:0] cross_sum;
  logic [63:0] p_nxt, p_r;

  // Partial products: the high-by-high term lies above bit 63 and is dropped,
  // and of the cross terms only their low halves reach the result.
  assign pll_nxt = 64'(a[31:0]) * 64'(b[31:0]);
  assign phl_nxt = a[63:32] * b[31:0];
  assign plh_nxt = a[31:0] * b[63:32];

  always_ff @(posedge clk) begin
    if (en.pp) begin
      pll_r <= pll_nxt;
      phl_r <= phl_nxt;
      plh_r <= plh_nxt;
    end
  end

  // Sum the cross terms into the upper word.
  assign cross_sum = phl_r + plh_r;
  assign p_nxt     = pll_r + {cross_sum, 32'd0};

  always_ff @(posedge clk) begin
    if (en.sum) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- hw/rtl/q31nr_seed.sv -----
// Front end of the divider: scales the operands to the working format and
// forms the linear seed of the reciprocal in two stages. Depends on q31nr_pkg.
`default_nettype none

module q31nr_seed
  import q31nr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          in_dividend,
  input  wire logic [31:0]          in_divisor,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [63:0]          out_xi,
  output logic      [FRAC_BITS:0]   out_num,
  output logic      [FRAC_BITS:0]   out_den,
  output logic                      out_spec
);

  localparam int NS   = 2;
  localparam int SP_W = FRAC_BITS + 1 + SLOPE_W;

  logic [NS-1:0]               v_r, en, v_in;
  logic [NS-1:0]               spec_r;
  logic [FRAC_BITS:0]          num_r [NS];
  logic [FRAC_BITS:0]          den_r [NS];
  logic [FRAC_BITS:0]          num_nxt;
  logic signed [FRAC_BITS:0]   den_nxt;
  logic                        spec_nxt;
  logic signed [SP_W-1:0]      sprod_nxt, sprod_r;
  logic [63:0]                 sprod_ext;
  logic [63:0]                 xi_nxt, xi_r;

  // A stage moves on when it is empty or when the stage after it moves on.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign v_in     = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 0: arithmetic shift to the working format keeps the top bits;
  // detect the one case the iteration cannot reach; multiply by the slope.
  assign num_nxt   = in_dividend[31 -: FRAC_BITS+1];
  assign den_nxt   = in_divisor[31 -: FRAC_BITS+1];
  assign spec_nxt  = (in_dividend == Q31_MIN) && (in_divisor == Q31_MIN);
  assign sprod_nxt = den_nxt * SEED_SLOPE;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sprod_r   <= sprod_nxt;
      num_r[0]  <= num_nxt;
      den_r[0]  <= den_nxt;
      spec_r[0] <= spec_nxt;
    end
  end

  // Stage 1: subtract the scaled product from the offset.
  assign sprod_ext = {{(64-SP_W){sprod_r[SP_W-1]}}, sprod_r};
  assign xi_nxt    = sat_sub64(SEED_OFFSET, 64'($signed(sprod_ext) >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xi_r      <= xi_nxt;
      num_r[1]  <= num_r[0];
      den_r[1]  <= den_r[0];
      spec_r[1] <= spec_r[0];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_xi    = xi_r;
  assign out_num   = num_r[NS-1];
  assign out_den   = den_r[NS-1];
  assign out_spec  = spec_r[NS-1];

`ifndef SYNTHESIS
  // The seed of any divisor in range is positive and below twice the offset.
  a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!xi_r[63] && (xi_r != '0) && (xi_r < (SEED_OFFSET << 1))))
    else $error("reciprocal seed out of its range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/q31nr_step.sv -----
// One Newton-Raphson refinement of the reciprocal, x + x*(1 - x*d), as a
// six-stage pipeline. Depends on q31nr_pkg and q31nr_mul64.
`default_nettype none

module q31nr_step
  import q31nr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [63:0]          in_xi,
  input  wire logic [FRAC_BITS:0]   in_num,
  input  wire logic [FRAC_BITS:0]   in_den,
  input  wire logic                 in_spec,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [63:0]          out_xi,
  output logic      [FRAC_BITS:0]   out_num,
  output logic      [FRAC_BITS:0]   out_den,
  output logic                      out_spec
);

  // Stage numbers.
  localparam int NS      = 6;
  localparam int ST_DPP  = 0;
  localparam int ST_DSUM = 1;
  localparam int ST_ERR  = 2;
  localparam int ST_TPP  = 3;
  localparam int ST_TSUM = 4;
  localparam int ST_ADD  = 5;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  logic [NS-1:0]      v_r, en, v_in;
  logic [NS-1:0]      spec_r;
  logic [63:0]        xi_r  [NS];
  logic [FRAC_BITS:0] num_r [NS];
  logic [FRAC_BITS:0] den_r [NS];
  logic [63:0]        den_ext;
  logic [63:0]        xd_p, xt_p;
  logic [63:0]        t_nxt, t_r;
  logic [63:0]        xi_nxt;
  mul_en_t            mul_d_en, mul_t_en;

  // A stage moves on when it is empty or when the stage after it moves on.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign v_in     = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // Operands and the current estimate travel along with the stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xi_r[0]   <= in_xi;
      num_r[0]  <= in_num;
      den_r[0]  <= in_den;
      spec_r[0] <= in_spec;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        xi_r[k]   <= (k == ST_ADD) ? xi_nxt : xi_r[k-1];
        num_r[k]  <= num_r[k-1];
        den_r[k]  <= den_r[k-1];
        spec_r[k] <= spec_r[k-1];
      end
    end
  end

  // Stages 0 and 1: x * d.
  assign den_ext      = {{(63-FRAC_BITS){in_den[FRAC_BITS]}}, in_den};
  assign mul_d_en.pp  = en[ST_DPP];
  assign mul_d_en.sum = en[ST_DSUM];

  q31nr_mul64 u_mul_d (
    .clk (clk),
    .en  (mul_d_en),
    .a   (in_xi),
    .b   (den_ext),
    .p   (xd_p)
  );

  // Stage 2: error term 1 - x*d.
  assign t_nxt = sat_sub64(ONE, 64'($signed(xd_p) >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en[ST_ERR]) begin
      t_r <= t_nxt;
    end
  end

  // Stages 3 and 4: x times the error term.
  assign mul_t_en.pp  = en[ST_TPP];
  assign mul_t_en.sum = en[ST_TSUM];

  q31nr_mul64 u_mul_t (
    .clk (clk),
    .en  (mul_t_en),
    .a   (xi_r[ST_ERR]),
    .b   (t_r),
    .p   (xt_p)
  );

  // Stage 5: correction added to the estimate.
  assign xi_nxt = sat_add64(xi_r[ST_TSUM], 64'($signed(xt_p) >>> FRAC_BITS));

  assign out_valid = v_r[NS-1];
  assign out_xi    = xi_r[NS-1];
  assign out_num   = num_r[NS-1];
  assign out_den   = den_r[NS-1];
  assign out_spec  = spec_r[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/q31nr_final.sv -----
// Back end of the divider: multiplies the dividend by the reciprocal and
// registers the Q31 quotient. Depends on q31nr_pkg and q31nr_mul64.
`default_nettype none

module q31nr_final
  import q31nr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [63:0]          in_xi,
  input  wire logic [FRAC_BITS:0]   in_num,
  input  wire logic                 in_spec,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [31:0]          out_quotient
);

  localparam int NS  = 3;
  localparam int QSH = 2 * FRAC_BITS - 31;

  logic [NS-1:0] v_r, en, v_in;
  logic [1:0]    spec_r;
  logic [63:0]   num_ext;
  logic [63:0]   prod;
  logic [31:0]   quotient_nxt, quotient_r;
  mul_en_t       mul_en;

  // A stage moves on when it is empty or when the stage after it moves on.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign v_in     = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // The special-case flag follows the multiplier stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      spec_r[0] <= in_spec;
    end
    if (en[1]) begin
      spec_r[1] <= spec_r[0];
    end
  end

  // Stages 0 and 1: n * x.
  assign num_ext    = {{(63-FRAC_BITS){in_num[FRAC_BITS]}}, in_num};
  assign mul_en.pp  = en[0];
  assign mul_en.sum = en[1];

  q31nr_mul64 u_mul_q (
    .clk (clk),
    .en  (mul_en),
    .a   (num_ext),
    .b   (in_xi),
    .p   (prod)
  );

  // Stage 2: rescale to Q31 and keep the low word; both operands at the most
  // negative value give the most positive quotient.
  assign quotient_nxt = spec_r[1] ? Q31_MAX : prod[QSH +: 32];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      quotient_r <= quotient_nxt;
    end
  end

  assign out_valid    = v_r[NS-1];
  assign out_quotient = quotient_r;

`ifndef SYNTHESIS
  // The special case must come out as the most positive value.
  a_spec_max: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && en[2] && spec_r[1]) |=> (quotient_r == Q31_MAX))
    else $error("special case did not yield the most positive quotient");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/q31_newton_raphson_divider.sv -----
// Q31 divider: linear reciprocal seed, Newton-Raphson refinement and a
// final multiply by the dividend, fully pipelined.
//
// Channels: in_ch carries a transaction of dividend and divisor (signed
// Q31); out_ch carries one signed Q31 quotient per input transaction, in
// the order the operands arrived. Both use valid/ready; a transaction
// completes on a rising clock edge with valid and ready high.
// Pipeline: two seed stages, six stages per refinement (two 64-bit
// multiplies of two stages each, a saturating subtract and a saturating
// add), and three output stages.
// Throughput: one transaction per cycle while out_ch.ready stays high; every stage has
// its own valid bit and moves on whenever the stage after it can take it.
// Stall: when out_ch.ready is low, the result and everything behind it
// hold; empty stages still fill, so in_ch.ready drops only once the whole
// pipeline is full. Nothing is dropped or repeated.
// Reset: rst_n (synchronous, active low) empties the pipeline; no divider
// state survives between transactions. Divisors are not normalized, so
// negative or tiny divisors give deterministic but meaningless quotients.
// Depends on q31nr_pkg, q31nr_if, q31nr_seed, q31nr_step and q31nr_final.
`default_nettype none

module q31_newton_raphson_divider
  import q31nr_pkg::*;
#(
  parameter int NR_ITERATIONS = NR_ITERATIONS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  q31nr_in_if.sink   in_ch,
  q31nr_out_if.source out_ch
);

  // Links between the seed, the refinement steps and the back end.
  logic [NR_ITERATIONS:0] ch_valid, ch_ready, ch_spec;
  logic [63:0]            ch_xi  [NR_ITERATIONS+1];
  logic [FRAC_BITS:0]     ch_num [NR_ITERATIONS+1];
  logic [FRAC_BITS:0]     ch_den [NR_ITERATIONS+1];

  // Operand scaling and reciprocal seed.
  q31nr_seed #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seed (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_dividend (in_ch.dividend),
    .in_divisor  (in_ch.divisor),
    .out_valid   (ch_valid[0]),
    .out_ready   (ch_ready[0]),
    .out_xi      (ch_xi[0]),
    .out_num     (ch_num[0]),
    .out_den     (ch_den[0]),
    .out_spec    (ch_spec[0])
  );

  // Refinement steps, one pipeline segment each.
  for (genvar i = 0; i < NR_ITERATIONS; i++) begin : g_step
    q31nr_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[i]),
      .in_ready  (ch_ready[i]),
      .in_xi     (ch_xi[i]),
      .in_num    (ch_num[i]),
      .in_den    (ch_den[i]),
      .in_spec   (ch_spec[i]),
      .out_valid (ch_valid[i+1]),
      .out_ready (ch_ready[i+1]),
      .out_xi    (ch_xi[i+1]),
      .out_num   (ch_num[i+1]),
      .out_den   (ch_den[i+1]),
      .out_spec  (ch_spec[i+1])
    );
  end

  // Quotient multiply and output register.
  q31nr_final #(
    .FRAC_BITS (FRAC_BITS)
  ) u_final (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (ch_valid[NR_ITERATIONS]),
    .in_ready     (ch_ready[NR_ITERATIONS]),
    .in_xi        (ch_xi[NR_ITERATIONS]),
    .in_num       (ch_num[NR_ITERATIONS]),
    .in_spec      (ch_spec[NR_ITERATIONS]),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_quotient (out_ch.quotient)
  );

`ifndef SYNTHESIS
  // Whenever the output side can move, every stage can, so input is taken.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_ch.valid || out_ch.ready) |-> in_ch.ready)
    else $error("input stalled although the output side is free");
`endif

endmodule

`default_nettype wire
